### design/mda_pkg.sv
// shared types, constants and helpers for the multidimensional array engine
// no dependencies; every other file depends on this package
package mda_pkg;

   localparam int HW_DIMS  = 4;
   localparam int NDIM_W   = 3;
   localparam int LEN_W    = 13;
   localparam int IDX_W    = 12;
   localparam int DATA_W   = 32;
   localparam int OFS_W    = 12;
   localparam int CSR_IX_W = 3;
   localparam int CSR_W    = LEN_W;

   localparam int DEF_MAX_DIMS   = 4;
   localparam int DEF_CAPACITY   = 4096;
   localparam int DEF_ELEM_WIDTH = 32;

   // register indexes of the configuration port
   localparam logic [CSR_IX_W-1:0] REG_NUM_DIMS = 3'd0;
   localparam logic [CSR_IX_W-1:0] REG_LEN_DIM0 = 3'd1;
   localparam logic [CSR_IX_W-1:0] REG_LEN_DIM1 = 3'd2;
   localparam logic [CSR_IX_W-1:0] REG_LEN_DIM2 = 3'd3;
   localparam logic [CSR_IX_W-1:0] REG_LEN_DIM3 = 3'd4;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_RANGE    = 2'd1,
      STATUS_CAPACITY = 2'd2
   } status_type;

   // configuration as seen by the access pipeline
   typedef struct packed {
      logic [NDIM_W-1:0]                dims;
      logic [HW_DIMS-1:0][LEN_W-1:0]    len;
      logic                             busy;
   } cfg_type;

   function automatic int eff_dims(input int max_dims);
      return (max_dims < HW_DIMS) ? max_dims : HW_DIMS;
   endfunction

endpackage

### design/mda_if.sv
// request and response channel interfaces with valid/ready handshake
// depends on mda_pkg
interface mda_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [mda_pkg::IDX_W-1:0] index_0;
   logic [mda_pkg::IDX_W-1:0] index_1;
   logic [mda_pkg::IDX_W-1:0] index_2;
   logic [mda_pkg::IDX_W-1:0] index_3;
   logic [mda_pkg::DATA_W-1:0] write_data;

   modport source (output valid, operation, index_0, index_1, index_2, index_3, write_data,
                   input ready);
   modport sink   (input valid, operation, index_0, index_1, index_2, index_3, write_data,
                   output ready);
endinterface

interface mda_rsp_if;
   logic                       valid;
   logic                       ready;
   mda_pkg::status_type        status;
   logic [mda_pkg::DATA_W-1:0] read_data;
   logic [mda_pkg::OFS_W-1:0]  element_offset;

   modport source (output valid, status, read_data, element_offset, input ready);
   modport sink   (input valid, status, read_data, element_offset, output ready);
endinterface

### design/mda_stride_gen.sv
// configuration registers and per-dimension stride derivation
// depends on mda_pkg
module mda_stride_gen #(
   parameter int MAX_DIMS = mda_pkg::DEF_MAX_DIMS,
   parameter int CAPACITY = mda_pkg::DEF_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mda_pkg::CSR_IX_W-1:0]  csr_index,
   input  logic [mda_pkg::CSR_W-1:0]     csr_wdata,
   output mda_pkg::cfg_type              cfg,
   output logic [mda_pkg::eff_dims(MAX_DIMS)-1:0][$clog2(CAPACITY+1)-1:0] stride
);
   import mda_pkg::*;

   localparam int EFF_DIMS = eff_dims(MAX_DIMS);
   localparam int STRIDE_W = $clog2(CAPACITY + 1);
   localparam int PROD_W   = LEN_W + STRIDE_W;
   localparam int SET_W    = $clog2(EFF_DIMS + 1);

   logic [NDIM_W-1:0]                num_dims_ff, num_dims_in;
   logic [HW_DIMS-1:0][LEN_W-1:0]    len_ff, len_in;
   logic [EFF_DIMS-1:0][STRIDE_W-1:0] stride_ff, stride_in;
   logic [SET_W-1:0]                 settle_ff, settle_in;
   logic [NDIM_W-1:0]                dims_eff;
   logic [NDIM_W-1:0]                dims_m1;

   // clamp dimension count to the supported range
   always_comb begin
      if (num_dims_ff == '0) begin
         dims_eff = NDIM_W'(1);
      end else if (num_dims_ff > NDIM_W'(EFF_DIMS)) begin
         dims_eff = NDIM_W'(EFF_DIMS);
      end else begin
         dims_eff = num_dims_ff;
      end
      dims_m1 = dims_eff - NDIM_W'(1);
   end

   always_comb begin
      num_dims_in = num_dims_ff;
      len_in      = len_ff;
      settle_in   = (settle_ff != '0) ? settle_ff - SET_W'(1) : settle_ff;
      if (csr_we) begin
         settle_in = SET_W'(EFF_DIMS);
         unique case (csr_index)
            REG_NUM_DIMS: num_dims_in = csr_wdata[NDIM_W-1:0];
            REG_LEN_DIM0: len_in[0]   = csr_wdata;
            REG_LEN_DIM1: len_in[1]   = csr_wdata;
            REG_LEN_DIM2: len_in[2]   = csr_wdata;
            REG_LEN_DIM3: len_in[3]   = csr_wdata;
            default: ;
         endcase
      end
   end

   // each stride follows from the one after it, one step per cycle
   for (genvar g = 0; g < EFF_DIMS; g++) begin : g_stride
      logic [PROD_W-1:0] prod;
      if (g < EFF_DIMS - 1) begin : g_mul
         assign prod = PROD_W'(len_ff[g+1]) * PROD_W'(stride_ff[g+1]);
      end else begin : g_last
         assign prod = '0;
      end
      always_comb begin
         if (NDIM_W'(g) == dims_m1) begin
            stride_in[g] = STRIDE_W'(1);
         end else if (NDIM_W'(g) > dims_m1) begin
            stride_in[g] = '0;
         end else if (prod > PROD_W'(CAPACITY)) begin
            stride_in[g] = STRIDE_W'(CAPACITY);
         end else begin
            stride_in[g] = prod[STRIDE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff  <= NDIM_W'(1);
         for (int i = 0; i < HW_DIMS; i++) begin
            len_ff[i] <= LEN_W'(1);
         end
         for (int i = 0; i < EFF_DIMS; i++) begin
            stride_ff[i] <= STRIDE_W'(i == 0);
         end
         settle_ff    <= '0;
      end else begin
         num_dims_ff <= num_dims_in;
         len_ff      <= len_in;
         stride_ff   <= stride_in;
         settle_ff   <= settle_in;
      end
   end

   assign cfg.dims = dims_eff;
   assign cfg.len  = len_ff;
   assign cfg.busy = (settle_ff != '0);
   assign stride   = stride_ff;

   chk_settle: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> cfg.busy)
      else $error("stride settle not started after register write");

   chk_last_one: assert property (@(posedge clock) disable iff (reset)
      !cfg.busy |-> stride_ff[dims_m1] == STRIDE_W'(1))
      else $error("innermost used stride is not one");

   chk_count: assert property (@(posedge clock) disable iff (reset)
      settle_ff <= SET_W'(EFF_DIMS))
      else $error("settle counter out of range");

endmodule

### design/mda_elem_store.sv
// element store: one write or one registered read per cycle
// depends on mda_pkg
module mda_elem_store #(
   parameter int CAPACITY   = mda_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = mda_pkg::DEF_ELEM_WIDTH
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic                        rd_en,
   input  logic [$clog2(CAPACITY)-1:0] addr,
   input  logic [mda_pkg::DATA_W-1:0]  wdata,
   output logic [mda_pkg::DATA_W-1:0]  rdata
);
   import mda_pkg::*;

   logic [ELEM_WIDTH-1:0] mem [CAPACITY];
   logic [ELEM_WIDTH-1:0] rd_q_ff;
   logic [ELEM_WIDTH-1:0] wr_elem;

   if (ELEM_WIDTH >= DATA_W) begin : g_wide
      assign wr_elem = ELEM_WIDTH'(wdata);
      assign rdata   = rd_q_ff[DATA_W-1:0];
   end else begin : g_narrow
      assign wr_elem = wdata[ELEM_WIDTH-1:0];
      assign rdata   = DATA_W'(rd_q_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_elem;
      end
      if (rd_en) begin
         rd_q_ff <= mem[addr];
      end
   end

endmodule

### design/multidim_array_access.sv
// top level of the row-major multidimensional array engine
// depends on mda_pkg, mda_if, mda_stride_gen and mda_elem_store
//
//   channel  dir  handshake            word
//   req      in   req.valid/req.ready  operation, index_0..3, write_data
//   rsp      out  rsp.valid/rsp.ready  status, read_data, element_offset
//   csr      in   csr_we               csr_index, csr_wdata
//
// three-stage pipeline: input register, stride products, offset sum with store access
// one word per cycle while no result stalls and strides are settled
// a register write holds req.ready low while strides settle
// a stalled result holds the whole pipeline; reset clears config and control only
module multidim_array_access #(
   parameter int MAX_DIMS   = mda_pkg::DEF_MAX_DIMS,
   parameter int CAPACITY   = mda_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = mda_pkg::DEF_ELEM_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   mda_req_if.sink                      req,
   mda_rsp_if.source                    rsp,
   input  logic                         csr_we,
   input  logic [mda_pkg::CSR_IX_W-1:0] csr_index,
   input  logic [mda_pkg::CSR_W-1:0]    csr_wdata
);
   import mda_pkg::*;

   localparam int EFF_DIMS = eff_dims(MAX_DIMS);
   localparam int STRIDE_W = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int PROD_W   = STRIDE_W + IDX_W;
   localparam int SUM_W    = PROD_W + 2;

   cfg_type                           cfg;
   logic [EFF_DIMS-1:0][STRIDE_W-1:0] stride;

   logic advance;
   logic accept;
   logic [HW_DIMS-1:0][IDX_W-1:0] req_idx;

   // stage 1
   logic                           s1_valid_ff;
   logic                           s1_op_ff;
   logic [EFF_DIMS-1:0][IDX_W-1:0] s1_idx_ff;
   logic [DATA_W-1:0]              s1_data_ff;
   // stage 2
   logic                            s2_valid_ff;
   logic                            s2_op_ff;
   logic                            s2_bad_ff, s2_bad_in;
   logic [EFF_DIMS-1:0][PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic [DATA_W-1:0]               s2_data_ff;
   // result stage
   logic              rsp_valid_ff;
   status_type        status_ff, status_in;
   logic [OFS_W-1:0]  offset_ff, offset_in;
   logic              rd_sel_ff;

   logic [SUM_W-1:0]  sum;
   logic              ok;
   logic              mem_we, mem_re;
   logic [DATA_W-1:0] mem_rdata;

   mda_stride_gen #(.MAX_DIMS(MAX_DIMS), .CAPACITY(CAPACITY)) u_stride (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .stride    (stride)
   );

   assign advance   = !(rsp_valid_ff && !rsp.ready);
   assign req.ready = advance && !cfg.busy;
   assign accept    = req.valid && req.ready;
   assign req_idx   = {req.index_3, req.index_2, req.index_1, req.index_0};

   // range check and stride products
   always_comb begin
      s2_bad_in = 1'b0;
      for (int i = 0; i < EFF_DIMS; i++) begin
         if ((NDIM_W'(i) < cfg.dims) && ({1'b0, s1_idx_ff[i]} >= cfg.len[i])) begin
            s2_bad_in = 1'b1;
         end
         s2_prod_in[i] = PROD_W'(stride[i]) * PROD_W'(s1_idx_ff[i]);
      end
   end

   // offset sum and capacity check
   always_comb begin
      sum = '0;
      for (int i = 0; i < EFF_DIMS; i++) begin
         sum = sum + SUM_W'(s2_prod_ff[i]);
      end
      ok = 1'b0;
      offset_in = '0;
      if (s2_bad_ff) begin
         status_in = STATUS_RANGE;
      end else if (sum >= SUM_W'(CAPACITY)) begin
         status_in = STATUS_CAPACITY;
      end else begin
         status_in = STATUS_OK;
         ok        = 1'b1;
         offset_in = sum[OFS_W-1:0];
      end
   end

   assign mem_we = advance && s2_valid_ff && ok && (s2_op_ff == OP_WRITE);
   assign mem_re = advance && s2_valid_ff && ok && (s2_op_ff == OP_READ);

   mda_elem_store #(.CAPACITY(CAPACITY), .ELEM_WIDTH(ELEM_WIDTH)) u_store (
      .clock (clock),
      .wr_en (mem_we),
      .rd_en (mem_re),
      .addr  (sum[ADDR_W-1:0]),
      .wdata (s2_data_ff),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff   <= req.operation;
         s1_data_ff <= req.write_data;
         for (int i = 0; i < EFF_DIMS; i++) begin
            s1_idx_ff[i] <= req_idx[i];
         end
         s2_op_ff   <= s1_op_ff;
         s2_bad_ff  <= s2_bad_in;
         s2_prod_ff <= s2_prod_in;
         s2_data_ff <= s1_data_ff;
         status_ff  <= status_in;
         offset_ff  <= offset_in;
         rd_sel_ff  <= mem_re;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = status_ff;
   assign rsp.element_offset = offset_ff;
   assign rsp.read_data      = rd_sel_ff ? mem_rdata : '0;

   chk_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status != STATUS_OK) |->
         (rsp.read_data == '0) && (rsp.element_offset == '0))
      else $error("error result carries data or offset");

   chk_busy_block: assert property (@(posedge clock) disable iff (reset)
      cfg.busy |-> !req.ready)
      else $error("request taken while strides settle");

   chk_csr_block: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req.ready)
      else $error("request taken right after a register write");

   chk_store_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> s2_valid_ff && !s2_bad_ff && (s2_op_ff == OP_WRITE) && !mem_re)
      else $error("store written by a rejected or read word");

endmodule

### dv/tb_multidim_array_access.sv
// self-checking testbench for the row-major multidimensional array engine
// carries its own shape, stride and element mirror to predict every response word
// depends on mda_pkg, mda_if and multidim_array_access
module tb_multidim_array_access;
   import mda_pkg::*;

   localparam int STORE_DEPTH     = DEF_CAPACITY;
   localparam int PIPE_TAIL       = 8;
   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_CYCLES     = 300;
   localparam int RANDOM_PHASES   = 32;
   localparam int WORDS_PER_PHASE = 58;
   localparam int PRINT_CAP       = 100;

   typedef struct packed {
      logic                          operation;
      logic [HW_DIMS-1:0][IDX_W-1:0] index;
      logic [DATA_W-1:0]             write_data;
   } access_word_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] read_data;
      logic [OFS_W-1:0]  element_offset;
   } access_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [CSR_IX_W-1:0] csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   mda_req_if req_if ();
   mda_rsp_if rsp_if ();

   multidim_array_access i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mirror of the block's shape and store
   logic [NDIM_W-1:0] cfg_dims;
   logic [LEN_W-1:0]  cfg_len   [HW_DIMS];
   logic [LEN_W-1:0]  stride_of [HW_DIMS];
   logic [DATA_W-1:0] elem_mirror [int];

   access_result_type pending_results [$];
   int                mismatches = 0;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                hold_requests;
   int                quiet_cycles = 0;

   function automatic int dims_used();
      if (cfg_dims == 0) return 1;
      if (cfg_dims > HW_DIMS) return HW_DIMS;
      return int'(cfg_dims);
   endfunction

   function automatic void recompute_strides();
      int              d;
      longint unsigned p;
      d = dims_used();
      for (int i = 0; i < HW_DIMS; i++) stride_of[i] = '0;
      stride_of[d-1] = 1;
      for (int i = d - 1; i > 0; i--) begin
         p = longint'(cfg_len[i]) * longint'(stride_of[i]);
         if (p > STORE_DEPTH) p = STORE_DEPTH;
         stride_of[i-1] = p[LEN_W-1:0];
      end
   endfunction

   function automatic status_type locate_element(input access_word_type w,
                                                 output logic [OFS_W-1:0] ofs);
      int              d;
      longint unsigned sum;
      bit              bad;
      d   = dims_used();
      sum = 0;
      bad = 1'b0;
      for (int i = 0; i < d; i++) begin
         if ({1'b0, w.index[i]} >= cfg_len[i]) bad = 1'b1;
         sum += longint'(stride_of[i]) * longint'(w.index[i]);
      end
      ofs = sum[OFS_W-1:0];
      if (bad) return STATUS_RANGE;
      if (sum >= STORE_DEPTH) return STATUS_CAPACITY;
      return STATUS_OK;
   endfunction

   function automatic access_result_type predict_access(input access_word_type w);
      access_result_type r;
      logic [OFS_W-1:0]  ofs;
      r.status         = locate_element(w, ofs);
      r.read_data      = '0;
      r.element_offset = '0;
      if (r.status == STATUS_OK) begin
         r.element_offset = ofs;
         if (w.operation == OP_WRITE) elem_mirror[int'(ofs)] = w.write_data;
         else r.read_data = elem_mirror[int'(ofs)];
      end
      return r;
   endfunction

   function automatic access_word_type mk_word(input logic op, input int i0, input int i1,
                                               input int i2, input int i3,
                                               input logic [DATA_W-1:0] data);
      access_word_type w;
      w.operation  = op;
      w.index[0]   = i0[IDX_W-1:0];
      w.index[1]   = i1[IDX_W-1:0];
      w.index[2]   = i2[IDX_W-1:0];
      w.index[3]   = i3[IDX_W-1:0];
      w.write_data = data;
      return w;
   endfunction

   // mostly in-range indices for the used dimensions, the rest noise
   function automatic access_word_type random_word();
      access_word_type w;
      int              d;
      int              lim;
      bit              in_range;
      d            = dims_used();
      in_range     = ($urandom_range(99) < 80);
      w.operation  = 1'($urandom_range(1));
      w.write_data = $urandom();
      for (int i = 0; i < HW_DIMS; i++) begin
         w.index[i] = IDX_W'($urandom());
         if (in_range && i < d && cfg_len[i] != 0) begin
            lim        = (cfg_len[i] > STORE_DEPTH) ? STORE_DEPTH : int'(cfg_len[i]);
            w.index[i] = IDX_W'($urandom_range(lim - 1));
         end
      end
      return w;
   endfunction

   task automatic note_mismatch(input string msg);
      if (mismatches < PRINT_CAP) $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic send_word(input access_word_type w);
      status_type       st;
      logic [OFS_W-1:0] ofs;
      // a read of a never-written element becomes a write
      st = locate_element(w, ofs);
      if (w.operation == OP_READ && st == STATUS_OK && !elem_mirror.exists(int'(ofs)))
         w.operation = OP_WRITE;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.operation  <= w.operation;
      req_if.index_0    <= w.index[0];
      req_if.index_1    <= w.index[1];
      req_if.index_2    <= w.index[2];
      req_if.index_3    <= w.index[3];
      req_if.write_data <= w.write_data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_results.push_back(predict_access(w));
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_TAIL) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IX_W-1:0] ix, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= ix;
      csr_wdata <= val;
      @(posedge clock);
      case (ix)
         REG_NUM_DIMS: cfg_dims   = val[NDIM_W-1:0];
         REG_LEN_DIM0: cfg_len[0] = val;
         REG_LEN_DIM1: cfg_len[1] = val;
         REG_LEN_DIM2: cfg_len[2] = val;
         REG_LEN_DIM3: cfg_len[3] = val;
         default: ;
      endcase
      recompute_strides();
   endtask

   task automatic end_reg_writes();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_shape(input logic [CSR_W-1:0] dims, input logic [CSR_W-1:0] l0,
                            input logic [CSR_W-1:0] l1, input logic [CSR_W-1:0] l2,
                            input logic [CSR_W-1:0] l3);
      wait_for_results();
      write_reg(REG_NUM_DIMS, dims);
      write_reg(REG_LEN_DIM0, l0);
      write_reg(REG_LEN_DIM1, l1);
      write_reg(REG_LEN_DIM2, l2);
      write_reg(REG_LEN_DIM3, l3);
      end_reg_writes();
   endtask

   function automatic logic [CSR_W-1:0] random_length();
      case ($urandom_range(19))
         0:       return '0;
         1:       return CSR_W'(STORE_DEPTH);
         2:       return '1;
         3:       return CSR_W'($urandom());
         default: return CSR_W'($urandom_range(6, 1));
      endcase
   endfunction

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 36;
            recv_idle_pct = 67;
         end
         1: begin
            send_idle_pct = 67;
            recv_idle_pct = 36;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic test_reset_defaults();
      send_word(mk_word(OP_WRITE, 0, 4095, 4095, 4095, '1));
      send_word(mk_word(OP_READ, 0, 4095, 0, 4095, '0));
      send_word(mk_word(OP_WRITE, 0, 0, 0, 0, '0));
      send_word(mk_word(OP_READ, 0, 0, 0, 0, '1));
      send_word(mk_word(OP_READ, 1, 0, 0, 0, '0));
      send_word(mk_word(OP_WRITE, 4095, 0, 0, 0, $urandom()));
   endtask

   // 16x16x16x16 makes the outer stride equal to the capacity, so any nonzero outer index overflows
   task automatic test_deep_shape();
      set_shape(4, 16, 16, 16, 16);
      send_word(mk_word(OP_WRITE, 0, 15, 15, 15, 32'hA5A5_5A5A));
      send_word(mk_word(OP_READ, 0, 15, 15, 15, '0));
      send_word(mk_word(OP_READ, 1, 0, 0, 0, '0));
      send_word(mk_word(OP_WRITE, 15, 15, 15, 15, '1));
      send_word(mk_word(OP_READ, 0, 16, 0, 0, '0));
   endtask

   task automatic test_dimension_count();
      set_shape(0, 4096, 0, 0, 0);
      send_word(mk_word(OP_READ, 4095, 4095, 4095, 4095, '0));
      send_word(mk_word(OP_WRITE, 4095, 0, 0, 0, 32'h0000_1234));
      set_shape(7, 1, 1, 0, 1);
      send_word(mk_word(OP_READ, 0, 0, 0, 0, '0));
      // upper bits of the count are dropped, 5 is clamped to the maximum
      set_shape(13'h1FFD, '1, '1, '1, '1);
      send_word(mk_word(OP_READ, 0, 0, 0, 4095, '0));
      send_word(mk_word(OP_READ, 0, 0, 1, 0, '0));
   endtask

   task automatic test_ignored_registers();
      set_shape(2, 3, 5, 1, 1);
      write_reg(3'd5, '1);
      write_reg(3'd6, '0);
      write_reg(3'd7, '1);
      end_reg_writes();
      send_word(mk_word(OP_WRITE, 2, 4, 4095, 4095, $urandom()));
      send_word(mk_word(OP_READ, 2, 4, 0, 0, '0));
      send_word(mk_word(OP_READ, 3, 0, 0, 0, '0));
   endtask

   task automatic test_random_shapes();
      logic [CSR_W-1:0] dims;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_idling(p * 3 / RANDOM_PHASES);
         dims = ($urandom_range(9) == 0) ? CSR_W'($urandom()) : CSR_W'($urandom_range(4, 1));
         set_shape(dims, random_length(), random_length(), random_length(), random_length());
         repeat (WORDS_PER_PHASE) send_word(random_word());
      end
   endtask

   task automatic test_backpressure();
      set_idling(2);
      set_shape(3, 4, 4, 4, 1);
      hold_requests++;
      repeat (20) send_word(random_word());
   endtask

   task automatic test_sender_pause();
      set_idling(0);
      repeat (10) send_word(random_word());
      wait_for_results();
      repeat (10) send_word(random_word());
   endtask

   // response side: ready pattern, long hold-off and checking
   initial begin
      access_result_type exp;
      int                hold_left;
      int                holds_served;
      rsp_if.ready = 1'b0;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_if.valid && rsp_if.ready) begin
               if (pending_results.size() == 0) begin
                  note_mismatch($sformatf("unexpected word: status %0d offset %0d",
                                          rsp_if.status, rsp_if.element_offset));
               end else begin
                  exp = pending_results.pop_front();
                  if (rsp_if.status !== exp.status)
                     note_mismatch($sformatf("status %0d, expected %0d",
                                             rsp_if.status, exp.status));
                  if (rsp_if.read_data !== exp.read_data)
                     note_mismatch($sformatf("read_data %h, expected %h",
                                             rsp_if.read_data, exp.read_data));
                  if (rsp_if.element_offset !== exp.element_offset)
                     note_mismatch($sformatf("element_offset %0d, expected %0d",
                                             rsp_if.element_offset, exp.element_offset));
               end
            end
            if (hold_requests != holds_served) begin
               holds_served = hold_requests;
               hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.operation  = OP_READ;
      req_if.index_0    = '0;
      req_if.index_1    = '0;
      req_if.index_2    = '0;
      req_if.index_3    = '0;
      req_if.write_data = '0;
      hold_requests     = 0;
      cfg_dims          = 1;
      for (int i = 0; i < HW_DIMS; i++) cfg_len[i] = 1;
      recompute_strides();
      set_idling(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_deep_shape();
      test_dimension_count();
      test_ignored_registers();
      test_random_shapes();
      test_backpressure();
      test_sender_pause();
      wait_for_results();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
